/* design/motor_drive_supervisor_core_assert.svh */
// ----------------------------------------------------------------------------
// Motor drive supervisor assertion macros
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef MOTOR_DRIVE_SUPERVISOR_CORE_ASSERT_SVH
`define MOTOR_DRIVE_SUPERVISOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motor drive supervisor assertion failed");

// Next-cycle implication
`define MDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motor drive supervisor assertion failed");

`else

`define MDS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define MDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/mds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor drive supervisor package
// Shared types, codes and constants for the supervisor core.
// ----------------------------------------------------------------------------
package mds_pkg;

    // Field widths
    localparam int ADC_W   = 12;
    localparam int MV_W    = 16;
    localparam int FAULT_W = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Defaults and fixed limits
    localparam int         CAL_SAMPLES_DEF = 256;
    localparam logic [15:0] ADC_FULL       = 16'd4095;

    // Opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ENABLE  = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    // Reported mode codes
    localparam logic [1:0] MODE_CAL   = 2'd0;
    localparam logic [1:0] MODE_READY = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_FAULT = 2'd3;

    // Fault flag bit positions
    localparam int FB_VLOW  = 0;
    localparam int FB_VHIGH = 1;
    localparam int FB_ENC   = 2;
    localparam int FB_SAT   = 3;
    localparam int FB_TEMP  = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VBUS_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VBUS_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FLOOR = 2'd3;

    // Configuration reset values
    localparam logic [MV_W-1:0]  VBUS_MIN_RST   = 16'd8000;
    localparam logic [MV_W-1:0]  VBUS_MAX_RST   = 16'd26000;
    localparam logic [ADC_W-1:0] TEMP_LIMIT_RST = 12'd3004;
    localparam logic [ADC_W-1:0] TEMP_FLOOR_RST = 12'd12;

    typedef enum logic [3:0] {
        ST_CAL   = 4'b0001,
        ST_READY = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_FAULT = 4'b1000
    } state_t;

    typedef logic [2:0][ADC_W-1:0] phase_codes_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [ADC_W-1:0] adc_iu;
        logic [ADC_W-1:0] adc_iv;
        logic [ADC_W-1:0] adc_iw;
        logic [ADC_W-1:0] adc_temp;
        logic [MV_W-1:0]  vbus_mv;
        logic             encoder_ok;
    } req_t;

    typedef struct packed {
        logic [MV_W-1:0]  vbus_min_mv;
        logic [MV_W-1:0]  vbus_max_mv;
        logic [ADC_W-1:0] temp_code_limit;
        logic [ADC_W-1:0] temp_code_floor;
    } cfg_t;

    typedef struct packed {
        logic accumulate;
        logic restart;
    } cal_ctrl_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [FAULT_W-1:0] fault_flags;
        logic               drive_on;
        logic               enable_accepted;
    } sup_result_t;

    typedef struct packed {
        sup_result_t  sup;
        phase_codes_t offsets;
    } rsp_t;

    function automatic logic [1:0] mode_code(input state_t st);
        logic [1:0] code;
        begin
            case (st)
                ST_CAL:   code = MODE_CAL;
                ST_READY: code = MODE_READY;
                ST_RUN:   code = MODE_RUN;
                ST_FAULT: code = MODE_FAULT;
                default:  code = MODE_CAL;
            endcase
            return code;
        end
    endfunction

    function automatic logic adc_saturated(input logic [ADC_W-1:0] code);
        return (code == '0) || ({{(16 - ADC_W){1'b0}}, code} == ADC_FULL);
    endfunction

endpackage

/* design/mds_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor drive supervisor channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mds_req_if
    import mds_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [ADC_W-1:0] adc_iu;
    logic [ADC_W-1:0] adc_iv;
    logic [ADC_W-1:0] adc_iw;
    logic [ADC_W-1:0] adc_temp;
    logic [MV_W-1:0]  vbus_mv;
    logic             encoder_ok;

    modport source (output valid, opcode, adc_iu, adc_iv, adc_iw, adc_temp, vbus_mv,
                    encoder_ok, input ready);
    modport sink   (input valid, opcode, adc_iu, adc_iv, adc_iw, adc_temp, vbus_mv,
                    encoder_ok, output ready);
endinterface

interface mds_rsp_if
    import mds_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [FAULT_W-1:0] fault_flags;
    logic               drive_on;
    logic               enable_accepted;
    logic [ADC_W-1:0]   offset_u;
    logic [ADC_W-1:0]   offset_v;
    logic [ADC_W-1:0]   offset_w;

    modport source (output valid, mode, fault_flags, drive_on, enable_accepted, offset_u,
                    offset_v, offset_w, input ready);
    modport sink   (input valid, mode, fault_flags, drive_on, enable_accepted, offset_u,
                    offset_v, offset_w, output ready);
endinterface

/* design/mds_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor drive supervisor configuration registers
// Write-only limit registers for bus voltage and NTC code window.
// ----------------------------------------------------------------------------
module mds_cfg_regs
    import mds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VBUS_MIN:   cfg_next.vbus_min_mv     = cfg_wdata;
                CFG_VBUS_MAX:   cfg_next.vbus_max_mv     = cfg_wdata;
                CFG_TEMP_LIMIT: cfg_next.temp_code_limit = cfg_wdata[ADC_W-1:0];
                CFG_TEMP_FLOOR: cfg_next.temp_code_floor = cfg_wdata[ADC_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vbus_min_mv     <= VBUS_MIN_RST;
            cfg_reg.vbus_max_mv     <= VBUS_MAX_RST;
            cfg_reg.temp_code_limit <= TEMP_LIMIT_RST;
            cfg_reg.temp_code_floor <= TEMP_FLOOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/mds_cal_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor drive supervisor calibration unit
// Sums phase-current codes and stores the rounded mean as zero offsets.
// ----------------------------------------------------------------------------
module mds_cal_unit
    import mds_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cal_ctrl_t    ctrl,
    input  phase_codes_t codes,
    output logic         done,
    output phase_codes_t offsets_next
);

    localparam int LogN   = $clog2(CAL_SAMPLES);
    localparam int SumW   = ADC_W + LogN;
    localparam int ShiftW = SumW + LogN;
    localparam int ProdW  = 2 * SumW + 1;
    localparam int CntW   = $clog2(CAL_SAMPLES + 1);
    // Reciprocal ceil(2^ShiftW / N): exact floor division for any SumW-bit sum
    localparam longint unsigned RecipFull =
        ((64'd1 << ShiftW) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [SumW:0]     Recip = RecipFull[SumW:0];
    // Sums start at N/2 so the stored mean rounds to nearest
    localparam logic [SumW-1:0]   Half  = SumW'(CAL_SAMPLES / 2);
    localparam logic [CntW-1:0]   CntN  = CntW'(CAL_SAMPLES);

    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic [SumW-1:0]  sum_reg [3];
    logic [SumW-1:0]  sum_next [3];
    phase_codes_t     offset_reg;
    phase_codes_t     quot;
    logic             store;

    // Sample counter: done marks the last sample of the run
    assign count_next = count_reg + 1'b1;
    assign done       = (count_next >= CntN);
    assign store      = ctrl.accumulate && done;

    // Per-phase accumulate and divide by reciprocal multiply
    for (genvar p = 0; p < 3; p++)
    begin : g_phase
        logic [ProdW-1:0] prod;

        assign sum_next[p] = sum_reg[p] + SumW'(codes[p]);
        assign prod        = ProdW'(sum_next[p]) * ProdW'(Recip);
        assign quot[p]     = prod[ShiftW +: ADC_W];
        assign offsets_next[p] = store ? quot[p] : offset_reg[p];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sum_reg[p]    <= Half;
                offset_reg[p] <= '0;
            end
            else if (ctrl.restart)
            begin
                sum_reg[p] <= Half;
            end
            else if (ctrl.accumulate)
            begin
                sum_reg[p] <= sum_next[p];
                if (done)
                begin
                    offset_reg[p] <= quot[p];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.restart)
        begin
            count_reg <= '0;
        end
        else if (ctrl.accumulate)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* design/mds_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor drive supervisor mode controller
// Calibrate/ready/run/fault state machine with run-time fault checks.
// ----------------------------------------------------------------------------
module mds_fsm
    import mds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  req_t        req,
    input  cfg_t        cfg,
    input  logic        cal_done,
    output cal_ctrl_t   cal_ctrl,
    output sup_result_t result
);

    state_t             state_reg;
    state_t             state_next;
    logic [FAULT_W-1:0] fault_reg;
    logic [FAULT_W-1:0] fault_next;
    logic               drive_reg;
    logic               drive_next;
    logic               accepted;
    logic [FAULT_W-1:0] flags;
    logic               vbus_in_window;

    // Run-time fault checks
    always_comb
    begin
        flags           = '0;
        flags[FB_VLOW]  = req.vbus_mv < cfg.vbus_min_mv;
        flags[FB_VHIGH] = req.vbus_mv > cfg.vbus_max_mv;
        flags[FB_ENC]   = !req.encoder_ok;
        flags[FB_SAT]   = adc_saturated(req.adc_iu) || adc_saturated(req.adc_iv) ||
                          adc_saturated(req.adc_iw) || adc_saturated(req.adc_temp);
        flags[FB_TEMP]  = (req.adc_temp <= cfg.temp_code_floor) ||
                          (req.adc_temp > cfg.temp_code_limit);
    end

    assign vbus_in_window = (req.vbus_mv >= cfg.vbus_min_mv) &&
                            (req.vbus_mv <= cfg.vbus_max_mv);

    // Next state for one transaction
    always_comb
    begin
        state_next = state_reg;
        fault_next = fault_reg;
        drive_next = drive_reg;
        accepted   = 1'b0;
        cal_ctrl   = '0;
        if (fire)
        begin
            case (req.opcode)
                OP_TICK:
                begin
                    case (state_reg)
                        ST_CAL:
                        begin
                            cal_ctrl.accumulate = 1'b1;
                            if (cal_done)
                            begin
                                state_next = ST_READY;
                            end
                        end
                        ST_RUN:
                        begin
                            fault_next = flags;
                            if (flags != '0)
                            begin
                                drive_next = 1'b0;
                                state_next = ST_FAULT;
                            end
                        end
                        ST_FAULT:
                        begin
                            drive_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = state_reg;
                        end
                    endcase
                end
                OP_ENABLE:
                begin
                    if ((state_reg == ST_READY) && vbus_in_window && req.encoder_ok)
                    begin
                        fault_next = '0;
                        drive_next = 1'b1;
                        state_next = ST_RUN;
                        accepted   = 1'b1;
                    end
                end
                OP_DISABLE:
                begin
                    drive_next = 1'b0;
                    fault_next = '0;
                    state_next = ST_READY;
                end
                OP_RESTART:
                begin
                    drive_next       = 1'b0;
                    fault_next       = '0;
                    cal_ctrl.restart = 1'b1;
                    state_next       = ST_CAL;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CAL;
            fault_reg <= '0;
            drive_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fault_reg <= fault_next;
            drive_reg <= drive_next;
        end
    end

    // Report the state after this transaction
    assign result.mode            = mode_code(state_next);
    assign result.fault_flags     = fault_next;
    assign result.drive_on        = drive_next;
    assign result.enable_accepted = accepted;

endmodule

/* design/motor_drive_supervisor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor drive supervisor core
// Gate driver supervisor: current offset calibration, enable gating and
// latched run-time fault detection.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake           Payload
//  req      in   valid/ready         opcode, adc_iu/iv/iw, adc_temp, vbus_mv,
//                                    encoder_ok
//  rsp      out  valid/ready         mode, fault_flags, drive_on,
//                                    enable_accepted, offset_u/v/w
//  cfg      in   cfg_we (no stall)   cfg_index, cfg_wdata
//
//  One transaction per cycle unless rsp stalls; results pass the input
//  register, then the result register. Each result is set by one pass through
//  the state update, the fault compares and the offset multiply. Reset puts
//  the block in calibrate with drive off, sums at N/2, flags and offsets
//  cleared. A stalled rsp holds its result; req still takes one transaction
//  into the input register, then stalls until the result is taken.
// ----------------------------------------------------------------------------
`include "motor_drive_supervisor_core_assert.svh"

module motor_drive_supervisor_core
    import mds_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    mds_req_if.sink              req,
    mds_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic         in_valid_reg;
    logic         in_valid_next;
    req_t         in_reg;
    logic         rsp_valid_reg;
    logic         rsp_valid_next;
    rsp_t         rsp_reg;
    logic         fire;
    logic         in_take;
    cfg_t         cfg;
    cal_ctrl_t    cal_ctrl;
    logic         cal_done;
    phase_codes_t offsets_next;
    phase_codes_t codes;
    sup_result_t  sup_result;
    logic         out_drive;
    logic         out_flagged;
    logic         out_accepted;

    // Advance the input register into the result register
    assign fire      = in_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;
    assign in_take   = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.opcode     <= req.opcode;
            in_reg.adc_iu     <= req.adc_iu;
            in_reg.adc_iv     <= req.adc_iv;
            in_reg.adc_iw     <= req.adc_iw;
            in_reg.adc_temp   <= req.adc_temp;
            in_reg.vbus_mv    <= req.vbus_mv;
            in_reg.encoder_ok <= req.encoder_ok;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg.sup     <= sup_result;
            rsp_reg.offsets <= offsets_next;
        end
    end

    assign codes[0] = in_reg.adc_iu;
    assign codes[1] = in_reg.adc_iv;
    assign codes[2] = in_reg.adc_iw;

    mds_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mds_cal_unit #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (cal_ctrl),
        .codes        (codes),
        .done         (cal_done),
        .offsets_next (offsets_next)
    );

    mds_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req      (in_reg),
        .cfg      (cfg),
        .cal_done (cal_done),
        .cal_ctrl (cal_ctrl),
        .result   (sup_result)
    );

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.mode            = rsp_reg.sup.mode;
    assign rsp.fault_flags     = rsp_reg.sup.fault_flags;
    assign rsp.drive_on        = rsp_reg.sup.drive_on;
    assign rsp.enable_accepted = rsp_reg.sup.enable_accepted;
    assign rsp.offset_u        = rsp_reg.offsets[0];
    assign rsp.offset_v        = rsp_reg.offsets[1];
    assign rsp.offset_w        = rsp_reg.offsets[2];

    // Qualify the offered result fields
    assign out_drive    = rsp_valid_reg && rsp_reg.sup.drive_on;
    assign out_flagged  = rsp_valid_reg && (rsp_reg.sup.fault_flags != '0);
    assign out_accepted = rsp_valid_reg && rsp_reg.sup.enable_accepted;

    // Drive is only ever on in run
    `MDS_ASSERT_IMP(a_drive_only_in_run, clk, rst_n, out_drive, rsp.mode == MODE_RUN)
    // Latched flags only remain in fault
    `MDS_ASSERT_IMP(a_flags_only_in_fault, clk, rst_n, out_flagged, rsp.mode == MODE_FAULT)
    // An accepted enable leaves the drive on
    `MDS_ASSERT_IMP(a_enable_drives, clk, rst_n, out_accepted, rsp.drive_on && rsp.mode == MODE_RUN)
    // Every processed transaction yields a pending result
    `MDS_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, rsp_valid_reg)

endmodule
